// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/plwoc_pkg.sv
package plwoc_pkg;

	localparam int DEF_SETS = 16;
	localparam int DEF_WAYS = 4;

	localparam int ID_W = 31;
	localparam int OP_W = 3;
	localparam int SEL_W = 4;
	localparam int ST_W = 4;
	localparam int WAY_OUT_W = 2;
	localparam int RC_W = 8;
	localparam int MAX_WB = 4;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_RETRIEVE = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_DIRTY    = 3'd2,
		OP_DEAD     = 3'd3,
		OP_SYNC     = 3'd4,
		OP_PROBE    = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_HIT_PINNED   = 4'd0,
		ST_HIT_UNPINNED = 4'd1,
		ST_LOADED       = 4'd2,
		ST_ABSENT       = 4'd3,
		ST_SET_FULL     = 4'd4,
		ST_STILL_HELD   = 4'd5,
		ST_UNPINNED     = 4'd6,
		ST_FREED_DEAD   = 4'd7,
		ST_WRITE_BACK   = 4'd8,
		ST_DONE         = 4'd9,
		ST_NOT_RESIDENT = 4'd10,
		ST_PRESENT      = 4'd11
	} status_t;

endpackage

// File: rtl/pinned_lru_writeback_object_cache_top.sv
// Set-associative object cache with pinning reference counts, least recently
// released replacement and write-back of dirty entries.
// Requests enter on the s_axis channel: tdata carries op, object_id, in_store and
// set_select from the lowest bit up. Results leave on the m_axis channel, one or
// more per request, with tlast set on the final result of each request.
// The state of one set is held in a synchronous memory word of all its ways. A
// request first forms the quotient for its set index by reciprocal multiplication,
// reads the set, decides in the next cycle and writes the set back.
// Each request passes through S_HASH, S_READ and S_DECIDE before its first result.
// Requests are handled one at a time and the next is taken in the cycle after the
// last result of the current one is registered for output. A sync visits one way a
// cycle, holding on a way it writes back while the output register is full, before
// its final result.
// When the receiver stalls, the waiting result holds in its output register and
// no new result is loaded until it has left; one further request may be taken
// meanwhile and is processed up to its first result.
// After reset the block clears the memory, one set a cycle, taking no request
// until the clear is done; every way is then invalid with rank equal to its index.
module pinned_lru_writeback_object_cache_top
	import plwoc_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// op[2:0], object_id[33:3], in_store[34], set_select[38:35], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[3:0], result_id[34:4], way[36:35], ref_count[44:37], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);

	// The set index is the object number modulo SETS; the quotient comes from a
	// multiplication by a rounded-up reciprocal that is exact for every 31-bit id.
	localparam int HASH_L = $clog2(SETS);
	localparam int HASH_SHIFT = ID_W + HASH_L;
	localparam logic [63:0] HASH_MAGIC =
		((64'd1 << HASH_SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);

	typedef struct packed {
		logic [ID_W-1:0]  tag;
		logic             valid;
		logic [RC_W-1:0]  rc;
		logic             dirty;
		logic             dead;
		logic [WAY_W-1:0] rank;
	} entry_t;

	typedef entry_t [WAYS-1:0] set_t;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [ID_W-1:0]      id;
		logic [WAY_OUT_W-1:0] way;
		logic [RC_W-1:0]      rc;
	} res_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_READ, S_DECIDE, S_EMIT, S_SYNC, S_FINAL
	} state_t;

	set_t mem [SETS];
	set_t rd_q;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic [OP_W-1:0] op_q;
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] quot_q;
	logic stored_q;
	logic [SEL_W-1:0] sel_q;
	logic [SET_W-1:0] set_q;
	set_t work_q;
	res_t pend_q;
	logic pend_v_q;
	logic [WCNT_W-1:0] wi_q;
	logic [2:0] nwb_q;
	logic sync_ok_q;

	logic out_v_q;
	res_t out_q;
	logic out_last_q;

	logic out_free;
	assign out_free = !out_v_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = {{(OUT_DATA_W - ST_W - ID_W - WAY_OUT_W - RC_W){1'b0}},
		out_q.rc, out_q.way, out_q.id, out_q.status};

	// Decision logic over the read set.
	logic hit;
	logic [WAY_W-1:0] hw;
	logic vic_ok;
	logic [WAY_W-1:0] vw;
	set_t nxt;
	res_t r0, r1;
	logic two;

	function automatic set_t mk_newest(set_t s, logic [WAY_W-1:0] w);
		set_t o;
		o = s;
		for (int i = 0; i < WAYS; i++) begin
			if (s[i].rank < s[w].rank) begin
				o[i].rank = s[i].rank + 1'b1;
			end
		end
		o[w].rank = '0;
		return o;
	endfunction

	function automatic set_t mk_oldest(set_t s, logic [WAY_W-1:0] w);
		set_t o;
		o = s;
		for (int i = 0; i < WAYS; i++) begin
			if (s[i].rank > s[w].rank) begin
				o[i].rank = s[i].rank - 1'b1;
			end
		end
		o[w].rank = WAY_W'(WAYS - 1);
		return o;
	endfunction

	always_comb begin
		hit = 1'b0;
		hw = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (rd_q[i].valid && rd_q[i].tag == id_q) begin
				hit = 1'b1;
				hw = WAY_W'(i);
			end
		end
		vic_ok = 1'b0;
		vw = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (rd_q[i].rc == '0 && (!vic_ok || rd_q[i].rank > rd_q[vw].rank)) begin
				vic_ok = 1'b1;
				vw = WAY_W'(i);
			end
		end
		nxt = rd_q;
		two = 1'b0;
		r0 = '{status: ST_DONE, id: id_q, way: '0, rc: '0};
		r1 = r0;
		unique case (op_q)
			OP_RETRIEVE: begin
				if (hit) begin
					if (rd_q[hw].rc != '0) begin
						if (rd_q[hw].rc != '1) begin
							nxt[hw].rc = rd_q[hw].rc + 1'b1;
						end
						r0 = '{ST_HIT_PINNED, id_q, WAY_OUT_W'(hw), nxt[hw].rc};
					end else begin
						nxt[hw].rc = RC_W'(1);
						r0 = '{ST_HIT_UNPINNED, id_q, WAY_OUT_W'(hw), RC_W'(1)};
					end
				end else if (!vic_ok) begin
					r0 = '{ST_SET_FULL, id_q, '0, '0};
				end else begin
					if (rd_q[vw].valid && rd_q[vw].dirty) begin
						two = 1'b1;
						r1 = '{ST_WRITE_BACK, rd_q[vw].tag, WAY_OUT_W'(vw), '0};
					end
					nxt[vw].dirty = 1'b0;
					nxt[vw].dead = 1'b0;
					if (stored_q) begin
						nxt[vw].tag = id_q;
						nxt[vw].valid = 1'b1;
						nxt[vw].rc = RC_W'(1);
						r0 = '{ST_LOADED, id_q, WAY_OUT_W'(vw), RC_W'(1)};
					end else begin
						nxt[vw].valid = 1'b0;
						nxt = mk_oldest(nxt, vw);
						r0 = '{ST_ABSENT, id_q, WAY_OUT_W'(vw), '0};
					end
				end
			end
			OP_RELEASE: begin
				if (!hit) begin
					r0 = '{ST_NOT_RESIDENT, id_q, '0, '0};
				end else if (rd_q[hw].rc == '0) begin
					r0 = '{ST_UNPINNED, id_q, WAY_OUT_W'(hw), '0};
				end else if (rd_q[hw].rc != RC_W'(1)) begin
					nxt[hw].rc = rd_q[hw].rc - 1'b1;
					r0 = '{ST_STILL_HELD, id_q, WAY_OUT_W'(hw), nxt[hw].rc};
				end else if (rd_q[hw].dead) begin
					nxt[hw].rc = '0;
					nxt[hw].valid = 1'b0;
					nxt[hw].dirty = 1'b0;
					nxt[hw].dead = 1'b0;
					nxt = mk_oldest(nxt, hw);
					r0 = '{ST_FREED_DEAD, id_q, WAY_OUT_W'(hw), '0};
				end else begin
					nxt[hw].rc = '0;
					nxt = mk_newest(nxt, hw);
					r0 = '{ST_UNPINNED, id_q, WAY_OUT_W'(hw), '0};
				end
			end
			OP_DIRTY, OP_DEAD: begin
				if (!hit) begin
					r0 = '{ST_NOT_RESIDENT, id_q, '0, '0};
				end else begin
					if (op_q == OP_DIRTY) begin
						nxt[hw].dirty = 1'b1;
					end else begin
						nxt[hw].dead = 1'b1;
					end
					r0 = '{ST_DONE, id_q, WAY_OUT_W'(hw), rd_q[hw].rc};
				end
			end
			OP_PROBE: begin
				if (hit) begin
					r0 = '{ST_PRESENT, id_q, WAY_OUT_W'(hw), rd_q[hw].rc};
				end else begin
					r0 = '{stored_q ? ST_PRESENT : ST_NOT_RESIDENT, id_q, '0, '0};
				end
			end
			default: begin
				r0 = '{ST_DONE, id_q, '0, '0};
			end
		endcase
	end

	// Sync: current way candidate.
	logic [WAY_W-1:0] wi;
	logic wb_take;
	assign wi = wi_q[WAY_W-1:0];
	assign wb_take = work_q[wi].valid && work_q[wi].dirty && !work_q[wi].dead &&
		(nwb_q < 3'(MAX_WB));

	logic out_load;
	assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_FINAL) ||
		(state_q == S_SYNC && wi_q != WCNT_W'(WAYS) && wb_take));

	logic [SET_W-1:0] rd_addr;
	logic rd_en;
	logic wr_en;
	logic [SET_W-1:0] wr_addr;
	set_t wr_data;
	set_t rst_set;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			rst_set[i] = '{tag: '0, valid: 1'b0, rc: '0, dirty: 1'b0, dead: 1'b0,
				rank: WAY_W'(i)};
		end
	end

	logic [SEL_W-1:0] in_sel;
	logic [ID_W-1:0] in_id;
	logic [63:0] prod;
	logic [ID_W-1:0] id_rem;
	logic [SET_W-1:0] cur_set;
	assign in_id = s_axis_tdata[OP_W +: ID_W];
	assign in_sel = s_axis_tdata[OP_W + ID_W + 1 +: SEL_W];
	assign prod = 64'(id_q) * HASH_MAGIC;
	assign id_rem = id_q - ID_W'(quot_q * ID_W'(SETS));
	assign cur_set = (op_q == OP_SYNC) ? SET_W'(sel_q) : SET_W'(id_rem);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = set_q;
		wr_en = 1'b0;
		wr_addr = set_q;
		wr_data = nxt;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_data = rst_set;
			end
			S_READ: begin
				rd_en = 1'b1;
				rd_addr = cur_set;
			end
			S_DECIDE: begin
				wr_en = (op_q != OP_SYNC);
			end
			S_FINAL: begin
				wr_en = sync_ok_q;
				wr_data = work_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
			pend_v_q <= 1'b0;
			wi_q <= '0;
			nwb_q <= '0;
			sync_ok_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tdata[OP_W-1:0];
						id_q <= in_id;
						stored_q <= s_axis_tdata[OP_W + ID_W];
						sel_q <= in_sel;
						sync_ok_q <= (32'(in_sel) < SETS);
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					quot_q <= ID_W'(prod >> HASH_SHIFT);
					state_q <= S_READ;
				end
				S_READ: begin
					set_q <= cur_set;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (op_q == OP_SYNC) begin
						work_q <= rd_q;
						wi_q <= '0;
						nwb_q <= '0;
						state_q <= sync_ok_q ? S_SYNC : S_FINAL;
					end else begin
						pend_q <= r0;
						pend_v_q <= two;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (pend_v_q) begin
							out_q <= r1;
							out_last_q <= 1'b0;
							pend_v_q <= 1'b0;
						end else begin
							out_q <= pend_q;
							out_last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SYNC: begin
					if (wi_q == WCNT_W'(WAYS)) begin
						state_q <= S_FINAL;
					end else if (!wb_take) begin
						wi_q <= wi_q + 1'b1;
					end else if (out_free) begin
						out_last_q <= 1'b0;
						out_q <= '{ST_WRITE_BACK, work_q[wi].tag, WAY_OUT_W'(wi),
							work_q[wi].rc};
						work_q[wi].dirty <= 1'b0;
						nwb_q <= nwb_q + 1'b1;
						wi_q <= wi_q + 1'b1;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						out_q <= '{ST_DONE, ID_W'(sel_q), '0, '0};
						state_q <= S_IDLE;
					end else begin
						sync_ok_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pending write-back result: r1 held in pend path through rd_q, which stays
	// stable until the next read.

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_no_req_in_clear, clk, arst_n, state_q == S_CLEAR, !s_axis_tready,
		"request accepted during memory clear")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled result changed")
	`ASSERT_IMPLY(a_sync_bound, clk, arst_n, state_q == S_SYNC, nwb_q <= 3'(MAX_WB),
		"too many write-backs in one sync")

endmodule
